// File: sv/tensor_transpose_address_gen_core_assert.svh
// Assertion macros for the transpose address generator.
// Used by the datapath module; expects clk and rst_n in scope.
`ifndef TENSOR_TRANSPOSE_ADDRESS_GEN_CORE_ASSERT_SVH
`define TENSOR_TRANSPOSE_ADDRESS_GEN_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TTA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TTA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tta_pkg.sv
// Shared types and constants for the transpose address generator.
// No dependencies.
package tta_pkg;

  localparam int MAX_RANK   = 4;
  localparam int DATA_BITS  = 32;
  localparam int INDEX_BITS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int PERM_BITS  = 8;
  localparam int ADDR_BITS  = 32;
  localparam int SEL_BITS   = $clog2(MAX_RANK);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [PERM_BITS-1:0] PERM_RESET = PERM_BITS'(228);

  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SIZE_0  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SIZE_1  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SIZE_2  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SIZE_3  = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_PERMUTATION = CFG_IDX_BITS'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_HOLD
  } tta_state_t;

  typedef struct packed {
    logic start;
    logic mac_en;
    logic emit_mac;
    logic emit_acc;
  } tta_cmd_t;

  typedef struct packed {
    logic out_free;
    logic step_last;
  } tta_status_t;

endpackage

// File: sv/tta_ctrl.sv
// Sequencer for the transpose address generator.
// Depends on tta_pkg; drives the datapath through tta_cmd_t.
module tta_ctrl
  import tta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tta_status_t status,
  output tta_cmd_t    cmd
);

  tta_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (status.step_last && status.out_free) begin
          cmd.emit_mac = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.mac_en = 1'b1;
          if (status.step_last) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (status.out_free) begin
          cmd.emit_acc = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/tta_dp.sv
// Datapath: configuration registers, axis counters, shared multiply-accumulate
// and output register. Depends on tta_pkg and the assertion macro header.
`include "tensor_transpose_address_gen_core_assert.svh"
module tta_dp
  import tta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  tta_cmd_t                 cmd,
  output tta_status_t              status,
  input  logic [DATA_BITS-1:0]     in_element_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_BITS-1:0]     out_value,
  output logic [ADDR_BITS-1:0]     out_address,
  output logic                     out_is_last,
  output logic                     out_order_error
);

  logic [SIZE_BITS-1:0]  dim_r [MAX_RANK];
  logic [PERM_BITS-1:0]  perm_r;
  logic [INDEX_BITS-1:0] cnt_r [MAX_RANK];
  logic [INDEX_BITS-1:0] cnt_nxt [MAX_RANK];
  logic [SEL_BITS-1:0]   step_r;
  logic [ADDR_BITS-1:0]  acc_r;
  logic [DATA_BITS-1:0]  val_r;

  logic                  out_valid_r;
  logic [DATA_BITS-1:0]  out_value_r;
  logic [ADDR_BITS-1:0]  out_address_r;
  logic                  out_is_last_r;
  logic                  out_order_error_r;

  logic [SIZE_BITS-1:0]  eff [MAX_RANK];
  logic [MAX_RANK-1:0]   at_end;
  logic [SEL_BITS-1:0]   sel;
  logic [ADDR_BITS+SIZE_BITS-1:0] prod;
  logic [ADDR_BITS-1:0]  mac;
  logic                  perm_bad;
  logic                  last_now;
  logic                  emit;
  logic                  cnt_zero;

  always_comb begin
    for (int a = 0; a < MAX_RANK; a++) begin
      eff[a]    = (dim_r[a] == '0) ? SIZE_BITS'(1) : dim_r[a];
      at_end[a] = ADDR_BITS'(cnt_r[a]) >= ADDR_BITS'(eff[a] - SIZE_BITS'(1));
    end
  end

  assign last_now = &at_end;
  assign emit     = cmd.emit_mac | cmd.emit_acc;

  always_comb begin
    perm_bad = 1'b0;
    for (int i = 0; i < MAX_RANK; i++) begin
      for (int j = i + 1; j < MAX_RANK; j++) begin
        if (perm_r[i*SEL_BITS +: SEL_BITS] == perm_r[j*SEL_BITS +: SEL_BITS]) begin
          perm_bad = 1'b1;
        end
      end
    end
  end

  assign sel  = perm_r[(cmd.start ? '0 : step_r)*SEL_BITS +: SEL_BITS];
  assign prod = (ADDR_BITS+SIZE_BITS)'(acc_r) * (ADDR_BITS+SIZE_BITS)'(eff[sel]);
  assign mac  = prod[ADDR_BITS-1:0] + ADDR_BITS'(cnt_r[sel]);

  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.step_last = (step_r == SEL_BITS'(MAX_RANK - 1));

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int a = MAX_RANK - 1; a >= 0; a--) begin
      cnt_nxt[a] = cnt_r[a];
      if (carry) begin
        if (at_end[a]) begin
          cnt_nxt[a] = '0;
        end else begin
          cnt_nxt[a] = cnt_r[a] + INDEX_BITS'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cnt_zero = 1'b1;
    for (int a = 0; a < MAX_RANK; a++) begin
      if (cnt_r[a] != '0) begin
        cnt_zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < MAX_RANK; a++) begin
        dim_r[a] <= SIZE_BITS'(1);
      end
      perm_r <= PERM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_SIZE_0:  dim_r[0] <= cfg_data[SIZE_BITS-1:0];
        REG_DIM_SIZE_1:  dim_r[1] <= cfg_data[SIZE_BITS-1:0];
        REG_DIM_SIZE_2:  dim_r[2] <= cfg_data[SIZE_BITS-1:0];
        REG_DIM_SIZE_3:  dim_r[3] <= cfg_data[SIZE_BITS-1:0];
        REG_PERMUTATION: perm_r   <= cfg_data[PERM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < MAX_RANK; a++) begin
        cnt_r[a] <= '0;
      end
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        step_r <= SEL_BITS'(1);
      end else if (cmd.mac_en) begin
        step_r <= step_r + SEL_BITS'(1);
      end
      if (emit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      val_r <= in_element_value;
      acc_r <= ADDR_BITS'(cnt_r[sel]);
    end else if (cmd.mac_en) begin
      acc_r <= mac;
    end
    if (emit) begin
      out_value_r       <= val_r;
      out_address_r     <= cmd.emit_mac ? mac : acc_r;
      out_is_last_r     <= last_now;
      out_order_error_r <= perm_bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_address     = out_address_r;
  assign out_is_last     = out_is_last_r;
  assign out_order_error = out_order_error_r;

  `TTA_ASSERT(a_emit_free, emit |-> (!out_valid_r || !out_stall), "result overwrote pending transfer")
  `TTA_ASSERT(a_last_wraps, (emit && last_now) |=> cnt_zero, "counters did not wrap after last")
  `TTA_ASSERT(a_cmd_excl, cmd.start |-> !(emit || cmd.mac_en), "start overlaps other command")
  `TTA_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// File: sv/tensor_transpose_address_gen_core.sv
// Transpose address generator: each element transfer first accepts the element
// and loads the outermost output index, then does one multiply-accumulate step
// for each remaining axis through a single shared 32x16 multiplier; a stalled
// output holds the transfer until the result register frees.
// Depends on tta_pkg, tta_ctrl and tta_dp.
module tensor_transpose_address_gen_core
  import tta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DATA_BITS-1:0]     in_element_value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_BITS-1:0]     out_value,
  output logic [ADDR_BITS-1:0]     out_address,
  output logic                     out_is_last,
  output logic                     out_order_error
);

  tta_cmd_t    cmd;
  tta_status_t status;

  tta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tta_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_element_value (in_element_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_address      (out_address),
    .out_is_last      (out_is_last),
    .out_order_error  (out_order_error)
  );

endmodule
